>>> hdl/lcs_pkg.sv
// Shared constants, control word types and the microprogram for the load cell reader.
package lcs_pkg;

    // Fixed field widths and constants of the reading path.
    localparam int READ_BITS         = 24;
    localparam int DIV_BITS          = 16;
    localparam int DATA_BITS_DEFAULT = 24;
    localparam int DIV_STEPS         = READ_BITS;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
    localparam logic [READ_BITS-1:0] OFFSET_FLIP   = 24'h800000;
    localparam logic [DIV_BITS-1:0]  DIVISOR_RESET = 16'd213;

    // Configuration register indexes.
    localparam logic REG_SCALE_DIVISOR = 1'b0;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_IDLE,
        OP_RISE,
        OP_FALL,
        OP_SHIFT,
        OP_FINISH,
        OP_TARE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_WEIGHT,
        OP_EMIT
    } op_t;

    // Jump conditions; the jump is taken when the condition holds.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_ACCEPT,
        C_PHASE_NZ,
        C_CLK_HIGH,
        C_PHASE_END,
        C_NOT_PENDING,
        C_NOT_ABOVE,
        C_DIV_MORE,
        C_OUT_BLOCKED
    } cond_t;

    // Program steps.
    typedef enum logic [3:0] {
        ST_FETCH,
        ST_CHECK,
        ST_IDLE,
        ST_TOGGLE,
        ST_RISE,
        ST_FALL,
        ST_SHIFT,
        ST_FINISH,
        ST_TARE,
        ST_COMPARE,
        ST_DIV,
        ST_WEIGHT,
        ST_EMIT,
        ST_RETURN
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Read-only control store: operation, jump condition and jump target per step.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t cw;
        unique case (step)
            ST_FETCH:   cw = '{OP_ACCEPT,   C_NO_ACCEPT,   ST_FETCH};
            ST_CHECK:   cw = '{OP_NOP,      C_PHASE_NZ,    ST_TOGGLE};
            ST_IDLE:    cw = '{OP_IDLE,     C_ALWAYS,      ST_EMIT};
            ST_TOGGLE:  cw = '{OP_NOP,      C_CLK_HIGH,    ST_FALL};
            ST_RISE:    cw = '{OP_RISE,     C_ALWAYS,      ST_EMIT};
            ST_FALL:    cw = '{OP_FALL,     C_PHASE_END,   ST_FINISH};
            ST_SHIFT:   cw = '{OP_SHIFT,    C_ALWAYS,      ST_EMIT};
            ST_FINISH:  cw = '{OP_FINISH,   C_NOT_PENDING, ST_COMPARE};
            ST_TARE:    cw = '{OP_TARE,     C_ALWAYS,      ST_EMIT};
            ST_COMPARE: cw = '{OP_DIV_LOAD, C_NOT_ABOVE,   ST_EMIT};
            ST_DIV:     cw = '{OP_DIV_STEP, C_DIV_MORE,    ST_DIV};
            ST_WEIGHT:  cw = '{OP_WEIGHT,   C_ALWAYS,      ST_EMIT};
            ST_EMIT:    cw = '{OP_EMIT,     C_OUT_BLOCKED, ST_EMIT};
            ST_RETURN:  cw = '{OP_NOP,      C_ALWAYS,      ST_FETCH};
            default:    cw = '{OP_NOP,      C_ALWAYS,      ST_FETCH};
        endcase
        return cw;
    endfunction

endpackage

>>> hdl/load_cell_serial_read_tare_scale.sv
// Top level of the two-wire load cell reader with tare and scaling.
//
// Each input word on the s_ channel is one half period of the converter's serial
// clock: s_tdata[0] is the sampled data line, s_tdata[1] a tare request. For every
// input word the block returns exactly one output word on the m_ channel holding
// the clock level to drive for that half period, the completion flag, the latest
// offset-binary reading, the held net weight and the update and tare flags.
// While idle the clock stays low until the data line reads low; then DATA_BITS
// pulses shift the reading in MSB first and one extra pulse follows.
// Control is a small microprogram. The word that completes a reading and updates the
// weight also runs the restoring divider, which resolves one quotient bit per cycle.
// After the emit step a return step passes before the fetch step takes the next word.
// A new input word is taken only when the program is back at its fetch step, so
// one word is in work at a time; the result sits in an output register, and a
// stalled receiver holds the program at its emit step until the register frees.
// The scale divisor is written over the APB port at address 0 (a zero acts as one).
// Synchronous active-low reset returns the sequencer to fetch, sets the divisor to 213,
// and clears all but the payload and divider registers; no clearing pass is needed.
module load_cell_serial_read_tare_scale
    import lcs_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] dout, [1] tare_request, [7:2] zero
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] sck, [1] reading_done, [25:2] raw_reading,
                                   // [49:26] weight, [50] weight_updated,
                                   // [51] tare_taken, [55:52] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PHASE_W = $clog2(DATA_BITS + 2);

    // Sequencer and datapath registers.
    step_t                  step_reg, step_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [READ_BITS-1:0]   shift_reg, shift_next;
    logic                   clk_level_reg, clk_level_next;
    logic [READ_BITS-1:0]   tare_reg, tare_next;
    logic [READ_BITS-1:0]   weight_reg, weight_next;
    logic [READ_BITS-1:0]   last_reg, last_next;
    logic                   pending_reg, pending_next;
    logic [DIV_BITS-1:0]    divisor_reg, divisor_next;
    logic                   din_reg, din_next;
    logic                   sck_reg, sck_next;
    logic                   done_reg, done_next;
    logic                   upd_reg, upd_next;
    logic                   tared_reg, tared_next;
    logic [DIV_BITS-1:0]    rem_reg, rem_next;
    logic [READ_BITS-1:0]   quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [55:0]            out_data_reg, out_data_next;

    ctrl_word_t             cw;
    logic                   s_accept;
    logic                   out_free;
    logic                   cond_true;
    logic                   cfg_write;
    logic [DIV_BITS-1:0]    div_eff;
    logic [DIV_BITS:0]      div_partial;
    logic [DIV_BITS:0]      div_diff;

    assign cw       = ucode_rom(step_reg);
    assign s_tready = (step_reg == ST_FETCH);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration port: writes land on the access cycle; reads return the divisor when paddr[2] is low, else zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SCALE_DIVISOR) ? {16'd0, divisor_reg} : 32'd0;

    // One divider step: shift the next dividend bit into the partial remainder.
    assign div_eff     = (divisor_reg == '0) ? DIV_BITS'(1) : divisor_reg;
    assign div_partial = {rem_reg, quot_reg[READ_BITS-1]};
    assign div_diff    = div_partial - {1'b0, div_eff};

    // Jump condition of the current control word.
    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:      cond_true = 1'b1;
            C_NO_ACCEPT:   cond_true = !s_accept;
            C_PHASE_NZ:    cond_true = (phase_reg != '0);
            C_CLK_HIGH:    cond_true = clk_level_reg;
            C_PHASE_END:   cond_true = (phase_reg > PHASE_W'(DATA_BITS));
            C_NOT_PENDING: cond_true = !pending_reg;
            C_NOT_ABOVE:   cond_true = !(last_reg > tare_reg);
            C_DIV_MORE:    cond_true = (cnt_reg != DIV_CNT_W'(DIV_STEPS - 1));
            C_OUT_BLOCKED: cond_true = !out_free;
            default:       cond_true = 1'b1;
        endcase
    end

    // Step counter: jump on condition, else fall through to the next step.
    always_comb begin
        if (cond_true) begin
            step_next = cw.target;
        end else begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    // Datapath actions selected by the control word.
    always_comb begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        clk_level_next = clk_level_reg;
        tare_next      = tare_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        pending_next   = pending_reg;
        din_next       = din_reg;
        sck_next       = sck_reg;
        done_next      = done_reg;
        upd_next       = upd_reg;
        tared_next     = tared_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (cw.op)
            OP_NOP: begin
            end
            OP_ACCEPT: begin
                if (s_accept) begin
                    din_next     = s_tdata[0];
                    pending_next = pending_reg || s_tdata[1];
                    sck_next     = 1'b0;
                    done_next    = 1'b0;
                    upd_next     = 1'b0;
                    tared_next   = 1'b0;
                end
            end
            OP_IDLE: begin
                sck_next       = 1'b0;
                clk_level_next = 1'b0;
                if (!din_reg) begin
                    phase_next = PHASE_W'(1);
                    shift_next = '0;
                end
            end
            OP_RISE: begin
                sck_next       = 1'b1;
                clk_level_next = 1'b1;
            end
            OP_FALL: begin
                sck_next       = 1'b0;
                clk_level_next = 1'b0;
            end
            OP_SHIFT: begin
                shift_next = {shift_reg[READ_BITS-2:0], din_reg};
                phase_next = phase_reg + PHASE_W'(1);
            end
            OP_FINISH: begin
                last_next  = shift_reg ^ OFFSET_FLIP;
                done_next  = 1'b1;
                phase_next = '0;
            end
            OP_TARE: begin
                tare_next    = last_reg;
                pending_next = 1'b0;
                tared_next   = 1'b1;
            end
            OP_DIV_LOAD: begin
                rem_next  = '0;
                quot_next = last_reg - tare_reg;
                cnt_next  = '0;
            end
            OP_DIV_STEP: begin
                if (!div_diff[DIV_BITS]) begin
                    rem_next = div_diff[DIV_BITS-1:0];
                end else begin
                    rem_next = div_partial[DIV_BITS-1:0];
                end
                quot_next = {quot_reg[READ_BITS-2:0], !div_diff[DIV_BITS]};
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
            end
            OP_WEIGHT: begin
                weight_next = quot_reg;
                upd_next    = 1'b1;
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, tared_reg, upd_reg, weight_reg, last_reg,
                                      done_reg, sck_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // Divisor register.
    always_comb begin
        divisor_next = divisor_reg;
        if (cfg_write && paddr[2] == REG_SCALE_DIVISOR) begin
            divisor_next = pwdata[DIV_BITS-1:0];
        end
    end

    // Register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_FETCH;
            phase_reg     <= '0;
            shift_reg     <= '0;
            clk_level_reg <= 1'b0;
            tare_reg      <= '0;
            weight_reg    <= '0;
            last_reg      <= '0;
            pending_reg   <= 1'b0;
            divisor_reg   <= DIVISOR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            clk_level_reg <= clk_level_next;
            tare_reg      <= tare_next;
            weight_reg    <= weight_next;
            last_reg      <= last_next;
            pending_reg   <= pending_next;
            divisor_reg   <= divisor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-word payload and divider working registers.
    always_ff @(posedge aclk) begin
        din_reg      <= din_next;
        sck_reg      <= sck_next;
        done_reg     <= done_next;
        upd_reg      <= upd_next;
        tared_reg    <= tared_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    // A completed reading always ends on a low clock half period.
    a_done_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("reading completed with the clock high");

    // Weight update and tare capture only happen on a completed reading, never together.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[50] || m_tdata[51]))
            |-> (m_tdata[1] && !(m_tdata[50] && m_tdata[51])))
        else $error("weight or tare flag without a completed reading");

    // An accepted word always starts the program at its decode step.
    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (step_reg == ST_CHECK))
        else $error("accepted word did not start the program");

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_DIV) |-> (cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count out of range");

    // The bit phase never runs beyond the extra pulse.
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> (phase_reg <= PHASE_W'(DATA_BITS + 1)))
        else $error("bit phase out of range");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the load cell serial reader with tare and scaling.
module tb
    import lcs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int FRAME_TICKS    = 2 * (DATA_BITS_DEFAULT + 1) + 1;
    localparam logic [2:0] DIVISOR_ADDR = 3'(REG_SCALE_DIVISOR) * 3'd4;

    // One result word, lowest field in the lowest bits.
    typedef struct packed {
        logic                 tare_taken;
        logic                 weight_updated;
        logic [READ_BITS-1:0] weight;
        logic [READ_BITS-1:0] raw_reading;
        logic                 reading_done;
        logic                 sck;
    } reader_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [0] dout, [1] tare_request, [7:2] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [0] sck, [1] reading_done, [25:2] raw_reading,
                                    // [49:26] weight, [50] weight_updated, [51] tare_taken
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    load_cell_serial_read_tare_scale u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Ticks waiting to be sent, {tare_request, dout}, and outputs still due.
    logic [1:0]  tick_queue[$];
    reader_out_t due_outputs[$];
    int unsigned error_count = 0;

    // Predictor state of the reader.
    logic [5:0]           rd_phase = '0;
    logic [READ_BITS-1:0] rd_shift = '0;
    logic                 rd_clock = 1'b0;
    logic [READ_BITS-1:0] rd_tare = '0;
    logic [READ_BITS-1:0] rd_weight = '0;
    logic [READ_BITS-1:0] rd_last = '0;
    logic                 rd_tare_pending = 1'b0;
    logic [DIV_BITS-1:0]  div_setting = DIVISOR_RESET;

    // Tare the stimulus generator expects the reader to hold.
    logic [READ_BITS-1:0] gen_tare = '0;

    task automatic note_failure(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Advances the predicted reader by one half period and returns its output word.
    function automatic reader_out_t advance_reader(input logic dout_bit, input logic tare_bit);
        reader_out_t          r;
        logic [READ_BITS-1:0] reading;
        logic [DIV_BITS-1:0]  div_eff;
        r = '0;
        if (tare_bit) rd_tare_pending = 1'b1;
        if (rd_phase == 0) begin
            rd_clock = 1'b0;
            if (!dout_bit) begin
                rd_phase = 6'd1;
                rd_shift = '0;
            end
        end else if (!rd_clock) begin
            r.sck = 1'b1;
            rd_clock = 1'b1;
        end else begin
            rd_clock = 1'b0;
            if (rd_phase <= DATA_BITS_DEFAULT) begin
                rd_shift = {rd_shift[READ_BITS-2:0], dout_bit};
                rd_phase = rd_phase + 6'd1;
            end else begin
                reading = rd_shift ^ OFFSET_FLIP;
                rd_last = reading;
                r.reading_done = 1'b1;
                rd_phase = '0;
                if (rd_tare_pending) begin
                    rd_tare = reading;
                    rd_tare_pending = 1'b0;
                    r.tare_taken = 1'b1;
                end else if (reading > rd_tare) begin
                    div_eff = (div_setting == 0) ? DIV_BITS'(1) : div_setting;
                    rd_weight = (reading - rd_tare) / div_eff;
                    r.weight_updated = 1'b1;
                end
            end
        end
        r.raw_reading = rd_last;
        r.weight = rd_weight;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
                s_tdata <= {6'b0, tick_queue.pop_front()};
                s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(0, 10);
                    gap_left <= $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches at random between modes, from always ready to rarely ready.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Monitor: check each result word first, then predict for each accepted input word.
    always @(posedge aclk) begin
        reader_out_t got;
        reader_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = reader_out_t'(m_tdata[51:0]);
            if (due_outputs.size() == 0) begin
                note_failure($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want = due_outputs.pop_front();
                if (got.sck !== want.sck)
                    note_failure($sformatf("sck %b, want %b", got.sck, want.sck));
                if (got.reading_done !== want.reading_done)
                    note_failure($sformatf("reading_done %b, want %b",
                                           got.reading_done, want.reading_done));
                if (got.raw_reading !== want.raw_reading)
                    note_failure($sformatf("raw_reading %h, want %h",
                                           got.raw_reading, want.raw_reading));
                if (got.weight !== want.weight)
                    note_failure($sformatf("weight %h, want %h", got.weight, want.weight));
                if (got.weight_updated !== want.weight_updated)
                    note_failure($sformatf("weight_updated %b, want %b",
                                           got.weight_updated, want.weight_updated));
                if (got.tare_taken !== want.tare_taken)
                    note_failure($sformatf("tare_taken %b, want %b",
                                           got.tare_taken, want.tare_taken));
            end
        end
        if (aresetn && s_tvalid && s_tready)
            due_outputs.push_back(advance_reader(s_tdata[0], s_tdata[1]));
    end

    // Watchdog on cycles in which no word moves on either channel.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("load_cell_serial_read_tare_scale test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_tick(input logic dout_bit, input logic tare_bit);
        tick_queue.push_back({tare_bit, dout_bit});
    endtask

    task automatic push_idle(input int n);
        repeat (n) push_tick(1'b1, 1'b0);
    endtask

    // One well-formed read: start tick, 24 data pulses and the extra pulse.
    // Tare requests land on tick indexes tare_a and tare_b (negative for none).
    task automatic push_frame(input logic [READ_BITS-1:0] bits, input int tare_a,
                              input int tare_b);
        int   k;
        logic t;
        push_tick(1'b0, tare_a == 0 || tare_b == 0);
        for (k = 0; k <= DATA_BITS_DEFAULT; k++) begin
            t = (tare_a == 2 * k + 1) || (tare_b == 2 * k + 1);
            // The data line is ignored on high ticks, so it is random there.
            push_tick(1'($urandom_range(0, 1)), t);
            t = (tare_a == 2 * k + 2) || (tare_b == 2 * k + 2);
            push_tick((k < DATA_BITS_DEFAULT) ? bits[READ_BITS-1-k]
                                              : 1'($urandom_range(0, 1)), t);
        end
        if (tare_a >= 0 || tare_b >= 0) gen_tare = bits ^ OFFSET_FLIP;
    endtask

    // Mostly well-formed reads with random content, sometimes line noise.
    task automatic push_random_segment();
        logic [READ_BITS-1:0] bits;
        int                   tare_a;
        int                   tare_b;
        int                   delta;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 40)) push_tick(1'($urandom_range(0, 1)), 1'b0);
            // Let any read started by the noise run out, then sit idle.
            push_idle(FRAME_TICKS + 1);
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    delta = $urandom_range(0, 4) - 2;
                    bits = (gen_tare + READ_BITS'(delta)) ^ OFFSET_FLIP;
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: bits = '0;
                        1: bits = '1;
                        2: bits = OFFSET_FLIP;
                        default: bits = ~OFFSET_FLIP;
                    endcase
                end
                default: bits = READ_BITS'($urandom);
            endcase
            tare_a = -1;
            tare_b = -1;
            if ($urandom_range(0, 5) == 0) begin
                tare_a = ($urandom_range(0, 2) == 0) ? FRAME_TICKS - 1
                                                     : $urandom_range(0, FRAME_TICKS - 1);
                if ($urandom_range(0, 3) == 0) tare_b = $urandom_range(0, FRAME_TICKS - 1);
            end
            push_idle($urandom_range(0, 3));
            push_frame(bits, tare_a, tare_b);
        end
    endtask

    // Holds until every tick is sent and every output word has come back.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_tvalid || due_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the divisor over APB and reads it back.
    task automatic write_divisor(input logic [DIV_BITS-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DIVISOR_ADDR;
        pwdata <= {16'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        div_setting = value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[DIV_BITS-1:0] !== value)
            note_failure($sformatf("divisor reads %h, want %h", prdata[DIV_BITS-1:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [DIV_BITS-1:0] divisor_plan[5];
        int                  p;
        divisor_plan[0] = 16'd1;
        divisor_plan[1] = 16'hFFFF;
        divisor_plan[2] = 16'd0;
        divisor_plan[3] = DIV_BITS'($urandom_range(2, 65534));
        divisor_plan[4] = DIVISOR_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed reads at the reset divisor.
        push_idle(2);
        push_tick(1'b1, 1'b1);                       // tare request while idle
        push_frame(OFFSET_FLIP, -1, -1);             // reading zero taken as tare
        push_frame(~OFFSET_FLIP, -1, -1);            // full-scale reading
        push_frame('0, FRAME_TICKS - 1, -1);         // tare on the completing tick
        push_frame('0, -1, -1);                      // reading equal to tare
        push_frame('1, -1, -1);                      // reading below tare
        push_frame(24'h000001, -1, -1);              // just above tare
        push_frame(24'h000001, -1, -1);              // same weight recomputed
        push_frame(24'h123456, 3, 20);               // repeated tare requests
        push_idle(1);
        repeat (2) push_random_segment();
        wait_drained();

        // Random phases, each at its own divisor.
        for (p = 0; p < 5; p++) begin
            write_divisor(divisor_plan[p]);
            repeat (2) push_random_segment();
            wait_drained();
        end

        if (due_outputs.size() != 0)
            note_failure($sformatf("%0d result words never arrived", due_outputs.size()));
        if (error_count == 0) begin
            $display("load_cell_serial_read_tare_scale test passed");
        end else begin
            $display("load_cell_serial_read_tare_scale test failed");
        end
        $finish;
    end

endmodule

>>> load_cell_serial_read_tare_scale.f
hdl/lcs_pkg.sv
hdl/load_cell_serial_read_tare_scale.sv
sim/tb.sv
